### rtl/core/pso_velocity_position_update_assert.svh
// Assertion macros for the PSO velocity/position update block.
// Used by files that include this header; needs clk and rst_n in scope.
`ifndef PSO_VELOCITY_POSITION_UPDATE_ASSERT_SVH
`define PSO_VELOCITY_POSITION_UPDATE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PVPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PVPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pvpu_pkg.sv
`timescale 1ns / 1ps
// Package for the PSO velocity/position update block: payload types,
// register map and fixed-point limits. No dependencies.
package pvpu_pkg;

  typedef struct packed {
    logic        [23:0] iteration;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] personal_best;
    logic signed [31:0] neighbour_best;
    logic        [15:0] uniform_one;
    logic        [15:0] uniform_two;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_position;
    logic               saturated;
  } out_item_t;

  // register index (paddr[4:2])
  localparam logic [2:0] RegInertiaMax = 3'd0;
  localparam logic [2:0] RegInertiaMin = 3'd1;
  localparam logic [2:0] RegTotalSteps = 3'd2;
  localparam logic [2:0] RegCogGain    = 3'd3;
  localparam logic [2:0] RegSocGain    = 3'd4;

  localparam logic [15:0] InertiaMaxRst = 16'd11957;
  localparam logic [15:0] InertiaMinRst = 16'd4915;
  localparam logic [23:0] TotalStepsRst = 24'd100000;
  localparam logic [15:0] GainRst       = 16'd24511;

  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  localparam int QuoBits = 16;

endpackage

### rtl/core/pso_velocity_position_update.sv
`timescale 1ns / 1ps
// Top level of the PSO velocity/position update block (single module).
// Depends on pvpu_pkg and pso_velocity_position_update_assert.svh.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  input   | start, busy, in_data (in_item_t)        | taken when start & !busy
//  result  | out_valid, out_data (out_item_t)        | one-cycle strobe, no backpressure
//  config  | psel, penable, pwrite, paddr, pwdata,   | APB write on access cycle,
//          | prdata, pready                          | pready tied high
//
// One item per cycle. Most of the pipeline is the inertia
// divider: 16 restoring compare/subtract stages, one quotient bit each.
// busy is always low; the pipeline never stalls and the receiver cannot stall it.
// rst_n (synchronous) clears the valid bits and loads register reset values;
// payload registers are not reset.
module pso_velocity_position_update
  import pvpu_pkg::*;
#(
  parameter int STEP_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  `include "pso_velocity_position_update_assert.svh"

  localparam logic [63:0] StepMaskWide = (64'd1 << STEP_BITS) - 64'd1;
  localparam logic [23:0] StepMask     = StepMaskWide[23:0];

  // ---------------------------------------------------------------- config
  logic [15:0] inertia_max_r, inertia_min_r, cog_gain_r, soc_gain_r;
  logic [23:0] total_steps_r;
  logic        wr_en;
  logic [25:0] steps_x3;
  logic [23:0] ramp_len;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_max_r <= InertiaMaxRst;
      inertia_min_r <= InertiaMinRst;
      total_steps_r <= TotalStepsRst;
      cog_gain_r    <= GainRst;
      soc_gain_r    <= GainRst;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        RegInertiaMax: inertia_max_r <= pwdata[15:0];
        RegInertiaMin: inertia_min_r <= pwdata[15:0];
        RegTotalSteps: total_steps_r <= pwdata[23:0];
        RegCogGain:    cog_gain_r    <= pwdata[15:0];
        RegSocGain:    soc_gain_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegInertiaMax: prdata = {16'd0, inertia_max_r};
      RegInertiaMin: prdata = {16'd0, inertia_min_r};
      RegTotalSteps: prdata = {8'd0, total_steps_r};
      RegCogGain:    prdata = {16'd0, cog_gain_r};
      RegSocGain:    prdata = {16'd0, soc_gain_r};
      default:       prdata = 32'd0;
    endcase
  end

  // decrease stage = floor(3*total/4); keep static while items are in flight (the block does not enforce this)
  assign steps_x3 = {1'b0, total_steps_r, 1'b0} + {2'b00, total_steps_r};
  assign ramp_len = steps_x3[25:2];

  // ---------------------------------------------------------------- stage 1
  // gains, differences, inertia numerator operands
  logic [23:0] step;
  logic [31:0] rho1_full, rho2_full;
  logic        s1_vld_r, s1_gt_r, s1_neg_r;
  logic signed [31:0] s1_pos_r, s1_vel_r;
  logic signed [32:0] s1_d1_r, s1_d2_r;
  logic [17:0] s1_rho1_r, s1_rho2_r;
  logic [15:0] s1_adiff_r;
  logic [23:0] s1_dsub_r;

  assign step      = in_data.iteration & StepMask;
  assign rho1_full = cog_gain_r * in_data.uniform_one;
  assign rho2_full = soc_gain_r * in_data.uniform_two;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    s1_pos_r   <= in_data.position;
    s1_vel_r   <= in_data.velocity;
    s1_d1_r    <= {in_data.personal_best[31], in_data.personal_best}
                - {in_data.position[31], in_data.position};
    s1_d2_r    <= {in_data.neighbour_best[31], in_data.neighbour_best}
                - {in_data.position[31], in_data.position};
    s1_rho1_r  <= rho1_full[31:14];
    s1_rho2_r  <= rho2_full[31:14];
    s1_gt_r    <= (ramp_len == 24'd0) || (step > ramp_len);
    s1_neg_r   <= inertia_max_r < inertia_min_r;
    s1_adiff_r <= (inertia_max_r < inertia_min_r) ? inertia_min_r - inertia_max_r
                                                  : inertia_max_r - inertia_min_r;
    s1_dsub_r  <= ramp_len - step;
  end

  // ---------------------------------------------------------------- stage 2
  // attraction products and |numerator|
  logic        s2_vld_r, s2_gt_r, s2_neg_r;
  logic signed [31:0] s2_pos_r, s2_vel_r;
  logic signed [51:0] s2_p1_r, s2_p2_r;
  logic [39:0] s2_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_pos_r <= s1_pos_r;
    s2_vel_r <= s1_vel_r;
    s2_gt_r  <= s1_gt_r;
    s2_neg_r <= s1_neg_r;
    s2_p1_r  <= $signed({1'b0, s1_rho1_r}) * s1_d1_r;
    s2_p2_r  <= $signed({1'b0, s1_rho2_r}) * s1_d2_r;
    s2_mag_r <= s1_adiff_r * s1_dsub_r;
  end

  // ---------------------------------------------------------------- divider
  // quotient < 2^16, so the remainder starts as mag[39:16] (< ramp_len)
  logic        dv_vld_r  [QuoBits];
  logic        dv_gt_r   [QuoBits];
  logic        dv_neg_r  [QuoBits];
  logic [23:0] dv_rem_r  [QuoBits];
  logic [15:0] dv_low_r  [QuoBits];
  logic [15:0] dv_quo_r  [QuoBits];
  logic signed [31:0] dv_pos_r  [QuoBits];
  logic signed [31:0] dv_vel_r  [QuoBits];
  logic signed [52:0] dv_rsum_r [QuoBits];

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    logic        vld_in, gt_in, neg_in, ge;
    logic [23:0] rem_in;
    logic [15:0] low_in, quo_in;
    logic signed [31:0] pos_in, vel_in;
    logic signed [52:0] rsum_in;
    logic [24:0] trial, diff;

    if (k == 0) begin : g_first
      assign vld_in  = s2_vld_r;
      assign gt_in   = s2_gt_r;
      assign neg_in  = s2_neg_r;
      assign rem_in  = s2_mag_r[39:16];
      assign low_in  = s2_mag_r[15:0];
      assign quo_in  = 16'd0;
      assign pos_in  = s2_pos_r;
      assign vel_in  = s2_vel_r;
      assign rsum_in = {s2_p1_r[51], s2_p1_r} + {s2_p2_r[51], s2_p2_r};
    end else begin : g_next
      assign vld_in  = dv_vld_r[k-1];
      assign gt_in   = dv_gt_r[k-1];
      assign neg_in  = dv_neg_r[k-1];
      assign rem_in  = dv_rem_r[k-1];
      assign low_in  = dv_low_r[k-1];
      assign quo_in  = dv_quo_r[k-1];
      assign pos_in  = dv_pos_r[k-1];
      assign vel_in  = dv_vel_r[k-1];
      assign rsum_in = dv_rsum_r[k-1];
    end

    assign trial = {rem_in, low_in[QuoBits-1-k]};
    assign ge    = trial >= {1'b0, ramp_len};
    assign diff  = trial - {1'b0, ramp_len};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k] <= 1'b0;
      else        dv_vld_r[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      dv_gt_r[k]   <= gt_in;
      dv_neg_r[k]  <= neg_in;
      dv_rem_r[k]  <= ge ? diff[23:0] : trial[23:0];
      dv_low_r[k]  <= low_in;
      dv_quo_r[k]  <= quo_in | (ge ? (16'd1 << (QuoBits-1-k)) : 16'd0);
      dv_pos_r[k]  <= pos_in;
      dv_vel_r[k]  <= vel_in;
      dv_rsum_r[k] <= rsum_in;
    end
  end

  // ---------------------------------------------------------------- inertia
  logic        wt_vld_r;
  logic [15:0] wt_w_r;
  logic signed [31:0] wt_pos_r, wt_vel_r;
  logic signed [52:0] wt_rsum_r;
  logic [15:0] q_last;

  assign q_last = dv_quo_r[QuoBits-1];

  always_ff @(posedge clk) begin
    if (!rst_n) wt_vld_r <= 1'b0;
    else        wt_vld_r <= dv_vld_r[QuoBits-1];
  end

  always_ff @(posedge clk) begin
    if (dv_gt_r[QuoBits-1])       wt_w_r <= inertia_min_r;
    else if (dv_neg_r[QuoBits-1]) wt_w_r <= inertia_min_r - q_last;
    else                          wt_w_r <= inertia_min_r + q_last;
    wt_pos_r  <= dv_pos_r[QuoBits-1];
    wt_vel_r  <= dv_vel_r[QuoBits-1];
    wt_rsum_r <= dv_rsum_r[QuoBits-1];
  end

  // ---------------------------------------------------------------- w * vel
  logic        mv_vld_r;
  logic signed [48:0] mv_wv_r;
  logic signed [31:0] mv_pos_r;
  logic signed [52:0] mv_rsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_vld_r <= 1'b0;
    else        mv_vld_r <= wt_vld_r;
  end

  always_ff @(posedge clk) begin
    mv_wv_r   <= $signed({1'b0, wt_w_r}) * wt_vel_r;
    mv_pos_r  <= wt_pos_r;
    mv_rsum_r <= wt_rsum_r;
  end

  // ---------------------------------------------------------------- round + sat velocity
  logic signed [55:0] acc;
  logic signed [39:0] nv_full;
  logic        rv_vld_r, rv_clip_r;
  logic signed [31:0] rv_nv_r, rv_pos_r;

  // Q.16 sum (16 fraction bits); add half an output LSB then floor (ties toward +inf)
  assign acc = {{5{mv_wv_r[48]}}, mv_wv_r, 2'b00}
             + {{3{mv_rsum_r[52]}}, mv_rsum_r}
             + 56'sd32768;
  assign nv_full = acc[55:16];

  always_ff @(posedge clk) begin
    if (!rst_n) rv_vld_r <= 1'b0;
    else        rv_vld_r <= mv_vld_r;
  end

  always_ff @(posedge clk) begin
    rv_pos_r <= mv_pos_r;
    if (nv_full > 40'sd2147483647) begin
      rv_nv_r   <= SatMax;
      rv_clip_r <= 1'b1;
    end else if (nv_full < -40'sd2147483648) begin
      rv_nv_r   <= SatMin;
      rv_clip_r <= 1'b1;
    end else begin
      rv_nv_r   <= nv_full[31:0];
      rv_clip_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- position + output
  logic signed [32:0] np_full;
  logic        out_vld_r;
  out_item_t   out_r;

  assign np_full = {rv_pos_r[31], rv_pos_r} + {rv_nv_r[31], rv_nv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= rv_vld_r;
  end

  always_ff @(posedge clk) begin
    out_r.new_velocity <= rv_nv_r;
    if (np_full[32] != np_full[31]) begin
      out_r.new_position <= np_full[32] ? SatMin : SatMax;
      out_r.saturated    <= 1'b1;
    end else begin
      out_r.new_position <= np_full[31:0];
      out_r.saturated    <= rv_clip_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  `PVPU_ASSERT_IMP(a_sat_at_rail, out_valid && out_data.saturated,
    out_data.new_velocity == SatMax || out_data.new_velocity == SatMin ||
    out_data.new_position == SatMax || out_data.new_position == SatMin,
    "saturated flag without a clipped result")
  `PVPU_ASSERT_IMP(a_w_in_range, wt_vld_r,
    (wt_w_r >= inertia_min_r && wt_w_r <= inertia_max_r) ||
    (wt_w_r <= inertia_min_r && wt_w_r >= inertia_max_r),
    "inertia weight outside its bounds")
  `PVPU_ASSERT_NXT(a_valid_flow, !rv_vld_r, !out_valid,
    "result strobe without an item in the last stage")
  `PVPU_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")

endmodule
